@@ sv/bmpp_pkg.sv @@
package bmpp_pkg;

  // Default depth of the p-free factorial table.
  localparam int unsigned TABLE_DEPTH_DEF = 65536;

  localparam int unsigned ARG_W  = 63;
  localparam int unsigned RES_W  = 16;
  localparam int unsigned PRIME_W = 16;
  localparam int unsigned EXP_W  = 5;

  // Register indexes on the configuration port.
  localparam logic REG_PRIME = 1'b0;
  localparam logic REG_EXP   = 1'b1;

  localparam logic [PRIME_W-1:0] PRIME_RESET = 16'd2;
  localparam logic [EXP_W-1:0]   EXP_RESET   = 5'd1;

  typedef struct packed {
    logic [ARG_W-1:0] n_value;
    logic [ARG_W-1:0] k_value;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] residue;
    logic             status;
  } out_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_LEG,
    ST_LEG_ACC,
    ST_TCHK,
    ST_MOD,
    ST_PHI,
    ST_TBL,
    ST_FILL,
    ST_FILL_WR,
    ST_PF_START,
    ST_PF_FULL,
    ST_PF_DIVM,
    ST_PF_POW0,
    ST_PF_MUL1,
    ST_PF_RD,
    ST_PF_RDW,
    ST_PF_NEXT,
    ST_PF_XP,
    ST_INV,
    ST_INV_P,
    ST_INV_MUL,
    ST_SCALE0,
    ST_SCALE,
    ST_SCALE_R,
    ST_OUT,
    ST_DIV_WAIT,
    ST_MM_MUL,
    ST_MM_DIV,
    ST_MM_WAIT,
    ST_PW,
    ST_PW_A,
    ST_PW_B,
    ST_PW_C
  } state_e;

endpackage

@@ sv/binomial_mod_prime_power.sv @@
// Binomial coefficient C(n,k) modulo p^q by the generalized Lucas method.
// Input channel: in_valid_i / in_stall_o carry one item with n_value and
// k_value. Output channel: out_valid_o / out_stall_i carry one item with
// residue and status. An item moves when valid is high and stall is low.
// The configuration port (APB style, pready always high) holds prime at
// address 0 and prime_exponent at address 4; a write marks the table stale.
// Trivial arguments go straight to the output. Otherwise the Legendre
// count divides by p once per base-p digit of n, k and n-k, all on one
// restoring divider that yields one bit per cycle. Every modular product
// then uses the multiplier, then the same divider, and each of up to 63
// recursion levels of the three p-free factorials does up to two divisions
// and a power costing up to two products per exponent bit. The first query
// after a register write fills the factorial table for modulus m. The
// block works on one item at a time; in_stall_o is high from acceptance
// until the result is loaded. A finished result waits in an output
// register while the receiver stalls, and the next item may be taken
// meanwhile. Reset clears control state, sets prime to 2 and exponent
// to 1, and marks the table invalid.
module binomial_mod_prime_power (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bmpp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bmpp_pkg::out_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  // Table depth, modulus width, table address width and divisor width.
  localparam int unsigned TABLE_DEPTH = bmpp_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned MW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned DW = (MW > 16) ? MW : 16;

  bmpp_pkg::state_e state_q, state_d;
  bmpp_pkg::state_e div_ret_q, div_ret_d;
  bmpp_pkg::state_e mm_ret_q, mm_ret_d;
  bmpp_pkg::state_e pw_ret_q, pw_ret_d;

  logic [15:0]     prime_q;
  logic [4:0]      pexp_q;
  logic            ready_q, ready_d;
  logic [MW-1:0]   modval_q, modval_d;

  logic [62:0]     n_q, n_d, k_q, k_d;
  logic [63:0]     x_q, x_d, t_q, t_d, e_q, e_d;
  logic [1:0]      idx_q, idx_d;
  logic [MW-1:0]   m_q, m_d, mdp_q, mdp_d, phi_q, phi_d;
  logic [4:0]      qcnt_q, qcnt_d;
  logic [MW-1:0]   base_q, base_d, pacc_q, pacc_d, acc_q, acc_d;
  logic [MW-1:0]   full_q, full_d, fn_q, fn_d, fk_q, fk_d;
  logic [MW-1:0]   mm_a_q, mm_a_d, mm_b_q, mm_b_d, mm_res_q, mm_res_d;
  logic [2*MW-1:0] prod_q, prod_d;
  logic [MW-1:0]   fill_i_q, fill_i_d, prev_q, prev_d, rx_q, rx_d;
  logic [15:0]     fill_pc_q, fill_pc_d;
  logic [15:0]     res_q, res_d;
  logic            stat_q, stat_d;
  bmpp_pkg::out_t  out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // Divider and table hookup.
  logic            div_start;
  logic [6:0]      div_count;
  logic [63:0]     div_dividend;
  logic [DW-1:0]   div_divisor;
  logic            div_busy;
  logic [63:0]     div_quot;
  logic [DW-1:0]   div_rem;
  logic            tbl_we;
  logic [AW-1:0]   tbl_waddr, tbl_raddr;
  logic [15:0]     tbl_wdata, tbl_rdata;

  // Derived operands.
  logic [15:0]     p_eff;
  logic [31:0]     p32, m32, mm32, rem32, acc32, rd32, prev32, rx32, mm1_32;
  logic [MW+15:0]  m_times_p, phi_w;
  logic [62:0]     nk;
  logic [MW-1:0]   m_minus1, fill_f;
  logic [15:0]     pc_inc;
  logic            cfg_wr;

  assign p_eff     = (prime_q < 16'd2) ? 16'd2 : prime_q;
  assign p32       = {16'b0, p_eff};
  assign m32       = 32'(m_q);
  assign mm32      = 32'(mm_res_q);
  assign rem32     = 32'(div_rem);
  assign acc32     = 32'(acc_q);
  assign rd32      = {16'b0, tbl_rdata};
  assign prev32    = {16'b0, mm32[15:0]};
  assign rx32      = 32'(rx_q);
  assign m_minus1  = m_q - MW'(1);
  assign mm1_32    = 32'(m_minus1);
  assign m_times_p = m_q * p_eff;
  assign phi_w     = mdp_q * (p_eff - 16'd1);
  assign nk        = n_q - k_q;
  assign pc_inc    = fill_pc_q + 16'd1;
  assign fill_f    = (fill_pc_q != 16'd0) ? fill_i_q : MW'(1);
  assign prod_d    = mm_a_q * mm_b_q;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bmpp_pkg::REG_EXP) ? {27'b0, pexp_q} : {16'b0, prime_q};

  assign in_stall_o  = (state_q != bmpp_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bmpp_div #(
    .DW(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .count_i   (div_count),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  bmpp_table #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmpp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if ((in_data_i.k_value > in_data_i.n_value) || (in_data_i.k_value == '0) ||
              (in_data_i.k_value == in_data_i.n_value)) begin
            state_d = bmpp_pkg::ST_OUT;
          end else begin
            state_d = bmpp_pkg::ST_LEG;
          end
        end
      end
      bmpp_pkg::ST_LEG: begin
        if (x_q == '0) begin
          state_d = (idx_q == 2'd2) ? bmpp_pkg::ST_TCHK : bmpp_pkg::ST_LEG;
        end else begin
          state_d = bmpp_pkg::ST_DIV_WAIT;
        end
      end
      bmpp_pkg::ST_LEG_ACC: state_d = bmpp_pkg::ST_LEG;
      bmpp_pkg::ST_TCHK: begin
        state_d = (t_q >= 64'(pexp_q)) ? bmpp_pkg::ST_OUT : bmpp_pkg::ST_MOD;
      end
      bmpp_pkg::ST_MOD: begin
        if (qcnt_q == pexp_q) begin
          state_d = bmpp_pkg::ST_PHI;
        end else if (m_times_p > (MW+16)'(TABLE_DEPTH)) begin
          state_d = bmpp_pkg::ST_OUT;
        end
      end
      bmpp_pkg::ST_PHI: state_d = bmpp_pkg::ST_TBL;
      bmpp_pkg::ST_TBL: begin
        state_d = (ready_q && (modval_q == m_q)) ? bmpp_pkg::ST_PF_START
                                                  : bmpp_pkg::ST_FILL;
      end
      bmpp_pkg::ST_FILL: begin
        state_d = (fill_i_q == m_q) ? bmpp_pkg::ST_PF_START : bmpp_pkg::ST_MM_MUL;
      end
      bmpp_pkg::ST_FILL_WR: state_d = bmpp_pkg::ST_FILL;
      bmpp_pkg::ST_PF_START: state_d = bmpp_pkg::ST_PF_FULL;
      bmpp_pkg::ST_PF_FULL: state_d = bmpp_pkg::ST_PF_DIVM;
      bmpp_pkg::ST_PF_DIVM: state_d = bmpp_pkg::ST_DIV_WAIT;
      bmpp_pkg::ST_PF_POW0: state_d = bmpp_pkg::ST_PW;
      bmpp_pkg::ST_PF_MUL1: state_d = bmpp_pkg::ST_MM_MUL;
      bmpp_pkg::ST_PF_RD: state_d = bmpp_pkg::ST_PF_RDW;
      bmpp_pkg::ST_PF_RDW: state_d = bmpp_pkg::ST_MM_MUL;
      bmpp_pkg::ST_PF_NEXT: begin
        if (x_q < {48'b0, p_eff}) begin
          state_d = (idx_q == 2'd2) ? bmpp_pkg::ST_INV : bmpp_pkg::ST_PF_START;
        end else begin
          state_d = bmpp_pkg::ST_DIV_WAIT;
        end
      end
      bmpp_pkg::ST_PF_XP: state_d = bmpp_pkg::ST_PF_DIVM;
      bmpp_pkg::ST_INV: state_d = bmpp_pkg::ST_MM_MUL;
      bmpp_pkg::ST_INV_P: state_d = bmpp_pkg::ST_PW;
      bmpp_pkg::ST_INV_MUL: state_d = bmpp_pkg::ST_MM_MUL;
      bmpp_pkg::ST_SCALE0: state_d = bmpp_pkg::ST_SCALE;
      bmpp_pkg::ST_SCALE: begin
        state_d = (qcnt_q == t_q[4:0]) ? bmpp_pkg::ST_OUT : bmpp_pkg::ST_MM_MUL;
      end
      bmpp_pkg::ST_SCALE_R: state_d = bmpp_pkg::ST_SCALE;
      bmpp_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = bmpp_pkg::ST_IDLE;
        end
      end
      bmpp_pkg::ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_d = div_ret_q;
        end
      end
      bmpp_pkg::ST_MM_MUL: state_d = bmpp_pkg::ST_MM_DIV;
      bmpp_pkg::ST_MM_DIV: state_d = bmpp_pkg::ST_MM_WAIT;
      bmpp_pkg::ST_MM_WAIT: begin
        if (!div_busy) begin
          state_d = mm_ret_q;
        end
      end
      bmpp_pkg::ST_PW: begin
        if (e_q == '0) begin
          state_d = pw_ret_q;
        end else if (e_q[0]) begin
          state_d = bmpp_pkg::ST_MM_MUL;
        end else begin
          state_d = bmpp_pkg::ST_PW_B;
        end
      end
      bmpp_pkg::ST_PW_A: state_d = bmpp_pkg::ST_PW_B;
      bmpp_pkg::ST_PW_B: begin
        // The last squaring is never used, so it is skipped.
        state_d = (e_q[63:1] == '0) ? bmpp_pkg::ST_PW : bmpp_pkg::ST_MM_MUL;
      end
      bmpp_pkg::ST_PW_C: state_d = bmpp_pkg::ST_PW;
      default: state_d = bmpp_pkg::ST_IDLE;
    endcase
  end

  // Datapath and unit control.
  always_comb begin
    div_ret_d   = div_ret_q;
    mm_ret_d    = mm_ret_q;
    pw_ret_d    = pw_ret_q;
    ready_d     = ready_q;
    modval_d    = modval_q;
    n_d         = n_q;
    k_d         = k_q;
    x_d         = x_q;
    t_d         = t_q;
    e_d         = e_q;
    idx_d       = idx_q;
    m_d         = m_q;
    mdp_d       = mdp_q;
    phi_d       = phi_q;
    qcnt_d      = qcnt_q;
    base_d      = base_q;
    pacc_d      = pacc_q;
    acc_d       = acc_q;
    full_d      = full_q;
    fn_d        = fn_q;
    fk_d        = fk_q;
    mm_a_d      = mm_a_q;
    mm_b_d      = mm_b_q;
    mm_res_d    = mm_res_q;
    fill_i_d    = fill_i_q;
    fill_pc_d   = fill_pc_q;
    prev_d      = prev_q;
    rx_d        = rx_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_start    = 1'b0;
    div_count    = 7'd64;
    div_dividend = x_q;
    div_divisor  = p32[DW-1:0];
    tbl_we       = 1'b0;
    tbl_waddr    = fill_i_q[AW-1:0];
    tbl_wdata    = mm32[15:0];
    tbl_raddr    = mm1_32[AW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bmpp_pkg::ST_IDLE: begin
        n_d    = in_data_i.n_value;
        k_d    = in_data_i.k_value;
        x_d    = {1'b0, in_data_i.n_value};
        t_d    = '0;
        idx_d  = 2'd0;
        stat_d = 1'b0;
        res_d  = ((in_data_i.k_value <= in_data_i.n_value) &&
                  ((in_data_i.k_value == '0) || (in_data_i.k_value == in_data_i.n_value)))
                 ? 16'd1 : 16'd0;
      end
      bmpp_pkg::ST_LEG: begin
        if (x_q == '0) begin
          idx_d = (idx_q == 2'd2) ? idx_q : idx_q + 2'd1;
          x_d   = (idx_q == 2'd0) ? {1'b0, k_q} : {1'b0, nk};
        end else begin
          div_start = 1'b1;
          div_ret_d = bmpp_pkg::ST_LEG_ACC;
        end
      end
      bmpp_pkg::ST_LEG_ACC: begin
        x_d = div_quot;
        t_d = (idx_q == 2'd0) ? t_q + div_quot : t_q - div_quot;
      end
      bmpp_pkg::ST_TCHK: begin
        res_d  = 16'd0;
        m_d    = MW'(1);
        qcnt_d = '0;
      end
      bmpp_pkg::ST_MOD: begin
        if (qcnt_q != pexp_q) begin
          if (m_times_p > (MW+16)'(TABLE_DEPTH)) begin
            stat_d = 1'b1;
          end else begin
            mdp_d  = m_q;
            m_d    = m_times_p[MW-1:0];
            qcnt_d = qcnt_q + 5'd1;
          end
        end
      end
      bmpp_pkg::ST_PHI: phi_d = phi_w[MW-1:0];
      bmpp_pkg::ST_TBL: begin
        idx_d = 2'd0;
        x_d   = {1'b0, n_q};
        if (!(ready_q && (modval_q == m_q))) begin
          // Entry zero is one for every modulus of at least two.
          tbl_we    = 1'b1;
          tbl_waddr = '0;
          tbl_wdata = 16'd1;
          fill_i_d  = MW'(1);
          fill_pc_d = 16'd1;
          prev_d    = MW'(1);
        end
      end
      bmpp_pkg::ST_FILL: begin
        if (fill_i_q == m_q) begin
          ready_d  = 1'b1;
          modval_d = m_q;
        end else begin
          mm_a_d   = prev_q;
          mm_b_d   = fill_f;
          mm_ret_d = bmpp_pkg::ST_FILL_WR;
        end
      end
      bmpp_pkg::ST_FILL_WR: begin
        tbl_we    = 1'b1;
        prev_d    = prev32[MW-1:0];
        fill_i_d  = fill_i_q + MW'(1);
        fill_pc_d = (pc_inc == p_eff) ? 16'd0 : pc_inc;
      end
      bmpp_pkg::ST_PF_START: begin
        acc_d = MW'(1);
      end
      bmpp_pkg::ST_PF_FULL: full_d = rd32[MW-1:0];
      bmpp_pkg::ST_PF_DIVM: begin
        div_start   = 1'b1;
        div_divisor = m32[DW-1:0];
        div_ret_d   = bmpp_pkg::ST_PF_POW0;
      end
      bmpp_pkg::ST_PF_POW0: begin
        e_d      = div_quot;
        rx_d     = rem32[MW-1:0];
        base_d   = full_q;
        pacc_d   = MW'(1);
        pw_ret_d = bmpp_pkg::ST_PF_MUL1;
      end
      bmpp_pkg::ST_PF_MUL1: begin
        mm_a_d   = acc_q;
        mm_b_d   = pacc_q;
        mm_ret_d = bmpp_pkg::ST_PF_RD;
      end
      bmpp_pkg::ST_PF_RD: begin
        acc_d     = mm_res_q;
        tbl_raddr = rx32[AW-1:0];
      end
      bmpp_pkg::ST_PF_RDW: begin
        mm_a_d   = acc_q;
        mm_b_d   = rd32[MW-1:0];
        mm_ret_d = bmpp_pkg::ST_PF_NEXT;
      end
      bmpp_pkg::ST_PF_NEXT: begin
        acc_d = mm_res_q;
        if (x_q < {48'b0, p_eff}) begin
          if (idx_q == 2'd0) begin
            fn_d = mm_res_q;
          end
          if (idx_q == 2'd1) begin
            fk_d = mm_res_q;
          end
          idx_d = (idx_q == 2'd2) ? idx_q : idx_q + 2'd1;
          x_d   = (idx_q == 2'd0) ? {1'b0, k_q} : {1'b0, nk};
        end else begin
          div_start = 1'b1;
          div_ret_d = bmpp_pkg::ST_PF_XP;
        end
      end
      bmpp_pkg::ST_PF_XP: x_d = div_quot;
      bmpp_pkg::ST_INV: begin
        mm_a_d   = fk_q;
        mm_b_d   = acc_q;
        mm_ret_d = bmpp_pkg::ST_INV_P;
      end
      bmpp_pkg::ST_INV_P: begin
        // Euler inverse: raise the denominator to phi - 1.
        e_d      = 64'(phi_q) - 64'd1;
        base_d   = mm_res_q;
        pacc_d   = MW'(1);
        pw_ret_d = bmpp_pkg::ST_INV_MUL;
      end
      bmpp_pkg::ST_INV_MUL: begin
        mm_a_d   = fn_q;
        mm_b_d   = pacc_q;
        mm_ret_d = bmpp_pkg::ST_SCALE0;
      end
      bmpp_pkg::ST_SCALE0: begin
        acc_d  = mm_res_q;
        qcnt_d = '0;
      end
      bmpp_pkg::ST_SCALE: begin
        if (qcnt_q == t_q[4:0]) begin
          res_d = acc32[15:0];
        end else begin
          mm_a_d   = acc_q;
          mm_b_d   = p32[MW-1:0];
          mm_ret_d = bmpp_pkg::ST_SCALE_R;
        end
      end
      bmpp_pkg::ST_SCALE_R: begin
        acc_d  = mm_res_q;
        qcnt_d = qcnt_q + 5'd1;
      end
      bmpp_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.residue = res_q;
          out_d.status  = stat_q;
          out_valid_d   = 1'b1;
        end
      end
      bmpp_pkg::ST_MM_DIV: begin
        div_start    = 1'b1;
        div_count    = 7'(2 * MW);
        div_dividend = {prod_q, {(64 - 2 * MW){1'b0}}};
        div_divisor  = m32[DW-1:0];
      end
      bmpp_pkg::ST_MM_WAIT: begin
        if (!div_busy) begin
          mm_res_d = rem32[MW-1:0];
        end
      end
      bmpp_pkg::ST_PW: begin
        if ((e_q != '0) && e_q[0]) begin
          mm_a_d   = pacc_q;
          mm_b_d   = base_q;
          mm_ret_d = bmpp_pkg::ST_PW_A;
        end
      end
      bmpp_pkg::ST_PW_A: pacc_d = mm_res_q;
      bmpp_pkg::ST_PW_B: begin
        if (e_q[63:1] == '0) begin
          e_d = '0;
        end else begin
          mm_a_d   = base_q;
          mm_b_d   = base_q;
          mm_ret_d = bmpp_pkg::ST_PW_C;
        end
      end
      bmpp_pkg::ST_PW_C: begin
        base_d = mm_res_q;
        e_d    = {1'b0, e_q[63:1]};
      end
      default: begin
      end
    endcase

    // Any register write invalidates the factorial table.
    if (cfg_wr) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmpp_pkg::ST_IDLE;
      div_ret_q   <= bmpp_pkg::ST_IDLE;
      mm_ret_q    <= bmpp_pkg::ST_IDLE;
      pw_ret_q    <= bmpp_pkg::ST_IDLE;
      ready_q     <= 1'b0;
      modval_q    <= '0;
      out_valid_q <= 1'b0;
      prime_q     <= bmpp_pkg::PRIME_RESET;
      pexp_q      <= bmpp_pkg::EXP_RESET;
      idx_q       <= '0;
      qcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      div_ret_q   <= div_ret_d;
      mm_ret_q    <= mm_ret_d;
      pw_ret_q    <= pw_ret_d;
      ready_q     <= ready_d;
      modval_q    <= modval_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      qcnt_q      <= qcnt_d;
      if (cfg_wr) begin
        if (paddr[2] == bmpp_pkg::REG_PRIME) begin
          prime_q <= pwdata[15:0];
        end else begin
          pexp_q <= pwdata[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    x_q       <= x_d;
    t_q       <= t_d;
    e_q       <= e_d;
    m_q       <= m_d;
    mdp_q     <= mdp_d;
    phi_q     <= phi_d;
    base_q    <= base_d;
    pacc_q    <= pacc_d;
    acc_q     <= acc_d;
    full_q    <= full_d;
    fn_q      <= fn_d;
    fk_q      <= fk_d;
    mm_a_q    <= mm_a_d;
    mm_b_q    <= mm_b_d;
    mm_res_q  <= mm_res_d;
    prod_q    <= prod_d;
    fill_i_q  <= fill_i_d;
    fill_pc_q <= fill_pc_d;
    prev_q    <= prev_d;
    rx_q      <= rx_d;
    res_q     <= res_d;
    stat_q    <= stat_d;
    out_q     <= out_d;
  end

endmodule

@@ sv/bmpp_div.sv @@
// Restoring divider, one quotient bit per cycle. The top count_i bits of the
// dividend are processed; the quotient is valid for a full 64-bit run.
module bmpp_div #(
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [6:0]    count_i,
  input  logic [63:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [63:0]   quot_o,
  output logic [DW-1:0] rem_o
);

  logic [63:0]   dvd_q, dvd_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dv_q, dv_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;

  assign trial = {rem_q, dvd_q[63]};
  assign take  = (trial >= {1'b0, dv_q});
  assign diff  = trial - {1'b0, dv_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dv_d   = divisor_i;
      cnt_d  = count_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = take ? diff[DW-1:0] : trial[DW-1:0];
      dvd_d  = {dvd_q[62:0], take};
      cnt_d  = cnt_q - 7'd1;
      busy_d = (cnt_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/bmpp_table.sv @@
// Single-port-write, single-port-read table with registered read data.
module bmpp_table #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
